FILE: rtl/core/grmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_pkg: shared types and constants of the grid ray march column block
// Payload structs, datapath command and status, controller states, fixed
// widths and the sine polynomial coefficients.
// ----------------------------------------------------------------------------
package grmc_pkg;

    // Parameter defaults
    localparam int GRID_SIZE_DEF      = 32;
    localparam int COLUMNS_DEF        = 320;
    localparam int ROWS_DEF           = 240;
    localparam int STEPS_PER_CELL_DEF = 16;
    localparam int MAX_STEPS_DEF      = 1024;

    // Fixed widths (cover the whole parameter range)
    localparam int POS_W   = 26;  // march position, signed Q.16
    localparam int FRAC_W  = 16;
    localparam int CELL_W  = POS_W - FRAC_W;  // signed cell index
    localparam int SIN_W   = 16;  // signed Q1.14
    localparam int STEP_W  = 17;  // signed step
    localparam int PROD_W  = POS_W + SIN_W;
    localparam int DIST_W  = PROD_W + 1;
    localparam int DEN_W   = DIST_W - 1;
    localparam int HALF_W  = 11;
    localparam int NUM_W   = HALF_W + 30;
    localparam int SHORT_W = 20;
    localparam int CFG_W   = 13;

    // Sine polynomial coefficients
    localparam logic [14:0] SIN_C0  = 15'd25736;
    localparam logic [13:0] SIN_C1  = 14'd10583;
    localparam logic [10:0] SIN_C2  = 11'd1306;
    localparam logic [14:0] SIN_ONE = 15'd16384;

    // Register reset values
    localparam logic [12:0] ORIGIN_RST = 13'd4096;
    localparam logic [11:0] VIEW_RST   = 12'd0;
    localparam logic [10:0] FOV_RST    = 11'd683;

    // Register indexes
    localparam logic [1:0] CFG_ORIGIN_X      = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y      = 2'd1;
    localparam logic [1:0] CFG_VIEW_ANGLE    = 2'd2;
    localparam logic [1:0] CFG_FIELD_OF_VIEW = 2'd3;

    // Actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    // Wall faces
    localparam logic [1:0] FACE_X_DEC = 2'd0;
    localparam logic [1:0] FACE_Y_DEC = 2'd1;
    localparam logic [1:0] FACE_Y_INC = 2'd2;
    localparam logic [1:0] FACE_X_INC = 2'd3;

    typedef struct packed {
        logic       action;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [7:0] cell_value;
        logic [8:0] column;
    } in_item_t;

    typedef struct packed {
        logic [8:0]         screen_column;
        logic               hit;
        logic [1:0]         wall_face;
        logic [8:0]         texture_u;
        logic signed [15:0] line_top;
        logic signed [15:0] line_bottom;
    } out_item_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLEAR,
        DP_CELL_WR,
        DP_CAST_LOAD,
        DP_ANG_TAKE,
        DP_SIN_A,
        DP_SIN_B,
        DP_SIN_C,
        DP_SIN_D,
        DP_SIN_E,
        DP_STEPX_START,
        DP_STEPX_TAKE,
        DP_STEPY_TAKE,
        DP_MARCH,
        DP_DIST_MUL,
        DP_NOHIT,
        DP_DIST_SUM,
        DP_H_START,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sin_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_busy;
        logic wall;
        logic d_pos;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ANG,
        ST_SIN_A,
        ST_SIN_B,
        ST_SIN_C,
        ST_SIN_D,
        ST_SIN_E,
        ST_STEPX,
        ST_STEPX_W,
        ST_STEPY_W,
        ST_MARCH,
        ST_DSUM,
        ST_DCHK,
        ST_HWAIT,
        ST_FINISH
    } ctrl_state_t;

    function automatic logic signed [15:0] sat16(input logic signed [DIST_W-1:0] v);
        logic signed [15:0] r;
        if (v > DIST_W'(32767)) begin
            r = 16'sd32767;
        end else if (v < -DIST_W'(32768)) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/grmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/grmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_div: restoring unsigned divider, one quotient bit per cycle
// Long mode runs the full numerator; short mode only its low SHORT_W bits.
// ----------------------------------------------------------------------------
module grmc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        short_mode,
    input  logic [grmc_pkg::NUM_W-1:0]  num,
    input  logic [grmc_pkg::DEN_W-1:0]  den,
    output logic                        busy,
    output logic [grmc_pkg::NUM_W-1:0]  quot
);
    localparam int NW = grmc_pkg::NUM_W;
    localparam int DW = grmc_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quot_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CW'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= short_mode ? (num << (NW - grmc_pkg::SHORT_W)) : num;
            cnt_reg  <= short_mode ? CW'(grmc_pkg::SHORT_W) : CW'(NW);
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= num_reg << 1;
            cnt_reg  <= cnt_reg - CW'(1);
            rem_reg  <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quot_reg <= {quot_reg[NW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
endmodule

FILE: rtl/core/grmc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_dp: datapath of the grid ray march column block
// Config registers, wall grid, sine unit, divider, march position, distance
// and the result register.
// ----------------------------------------------------------------------------
module grmc_dp #(
    parameter int GRID_SIZE      = grmc_pkg::GRID_SIZE_DEF,
    parameter int COLUMNS        = grmc_pkg::COLUMNS_DEF,
    parameter int ROWS           = grmc_pkg::ROWS_DEF,
    parameter int STEPS_PER_CELL = grmc_pkg::STEPS_PER_CELL_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [grmc_pkg::CFG_W-1:0]  cfg_data,
    input  grmc_pkg::in_item_t          s_data,
    output grmc_pkg::out_item_t         m_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  grmc_pkg::dp_cmd_t           cmd,
    output grmc_pkg::dp_stat_t          st
);
    localparam int PW    = grmc_pkg::POS_W;
    localparam int FW    = grmc_pkg::FRAC_W;
    localparam int CLW   = grmc_pkg::CELL_W;
    localparam int SW    = grmc_pkg::SIN_W;
    localparam int STW   = grmc_pkg::STEP_W;
    localparam int NW    = grmc_pkg::NUM_W;
    localparam int DW    = grmc_pkg::DEN_W;
    localparam int DSW   = grmc_pkg::DIST_W;
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(GRID_SIZE);
    localparam logic [grmc_pkg::HALF_W-1:0] HALF = grmc_pkg::HALF_W'(ROWS / 2);
    localparam logic [8:0] COL_LAST = 9'(COLUMNS - 1);

    // Reciprocals for the divisions by constants (exact over the operand range)
    localparam int CFW    = 20;  // column * field of view
    localparam int COL_S  = CFW + $clog2(COLUMNS);
    localparam logic [CFW+1:0] COL_M =
        (CFW+2)'(((64'd1 << COL_S) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));
    localparam int SNW    = 17;  // |sine| * 4
    localparam int STEP_S = SNW + $clog2(STEPS_PER_CELL);
    localparam logic [SNW+1:0] STEP_M =
        (SNW+2)'(((64'd1 << STEP_S) + 64'(STEPS_PER_CELL) - 64'd1)
                 / 64'(STEPS_PER_CELL));

    // Config
    logic [12:0] origin_x_reg, origin_y_reg;
    logic [11:0] view_reg;
    logic [10:0] fov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= grmc_pkg::ORIGIN_RST;
            origin_y_reg <= grmc_pkg::ORIGIN_RST;
            view_reg     <= grmc_pkg::VIEW_RST;
            fov_reg      <= grmc_pkg::FOV_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                grmc_pkg::CFG_ORIGIN_X:      origin_x_reg <= cfg_data;
                grmc_pkg::CFG_ORIGIN_Y:      origin_y_reg <= cfg_data;
                grmc_pkg::CFG_VIEW_ANGLE:    view_reg     <= cfg_data[11:0];
                grmc_pkg::CFG_FIELD_OF_VIEW: fov_reg      <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Wall grid and clearing sweep
    logic [AW-1:0] clr_addr_reg;
    logic          ram_we, ram_wdata, ram_rdata, wr_in_range;
    logic [AW-1:0] ram_waddr, ram_raddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.op == grmc_pkg::DP_CLEAR) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign wr_in_range = ({4'b0, s_data.cell_x} < 9'(GRID_SIZE))
                      && ({4'b0, s_data.cell_y} < 9'(GRID_SIZE));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = 1'b0;
        if (cmd.op == grmc_pkg::DP_CLEAR) begin
            ram_we = 1'b1;
        end else if (cmd.op == grmc_pkg::DP_CELL_WR) begin
            ram_we    = wr_in_range;
            ram_waddr = AW'(int'(s_data.cell_y) * GRID_SIZE + int'(s_data.cell_x));
            ram_wdata = (s_data.cell_value == 8'd1);
        end
    end

    grmc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Divider
    logic          div_start, div_short, div_busy;
    logic [NW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;

    // Angle and sine
    logic [8:0]           column_reg;
    logic [CFW-1:0]       colfov_reg;
    logic [2*CFW+1:0]     ang_prod;
    logic [11:0]          ang_q;
    logic [11:0]          ray_reg;
    logic [11:0]          sin_ang;
    logic [10:0]          r_reg, t2_reg;
    logic                 neg_reg;
    logic [13:0]          inner_reg;
    logic [14:0]          p_reg;
    logic signed [SW-1:0] sin_reg [4];
    logic [21:0]          sq, m1;
    logic [24:0]          m2;
    logic [25:0]          m3;
    logic [14:0]          smag;
    logic [14:0]          mag_x, mag_y;

    assign ang_prod = (2*CFW+2)'(colfov_reg) * (2*CFW+2)'(COL_M);
    assign ang_q    = 12'(ang_prod >> COL_S);
    assign sin_ang = (cmd.sin_sel[1] ? view_reg : ray_reg)
                   + (cmd.sin_sel[0] ? 12'd1024 : 12'd0);
    assign sq   = 22'(r_reg) * 22'(r_reg);
    assign m1   = 22'(grmc_pkg::SIN_C2) * 22'(t2_reg);
    assign m2   = 25'(inner_reg) * 25'(t2_reg);
    assign m3   = 26'(p_reg) * 26'(r_reg);
    assign smag = (m3[24:10] > grmc_pkg::SIN_ONE) ? grmc_pkg::SIN_ONE : m3[24:10];
    assign mag_x = sin_reg[0][SW-1] ? 15'(-sin_reg[0]) : 15'(sin_reg[0]);
    assign mag_y = sin_reg[1][SW-1] ? 15'(-sin_reg[1]) : 15'(sin_reg[1]);

    always_ff @(posedge aclk) begin
        case (cmd.op)
            grmc_pkg::DP_CAST_LOAD: begin
                column_reg <= s_data.column;
                colfov_reg <= 20'(s_data.column) * 20'(fov_reg);
            end
            grmc_pkg::DP_ANG_TAKE:
                ray_reg <= view_reg - {1'b0, fov_reg[10:1]} + ang_q;
            grmc_pkg::DP_SIN_A: begin
                r_reg   <= sin_ang[10] ? (11'd1024 - {1'b0, sin_ang[9:0]})
                                       : {1'b0, sin_ang[9:0]};
                neg_reg <= sin_ang[11];
            end
            grmc_pkg::DP_SIN_B: t2_reg    <= sq[20:10];
            grmc_pkg::DP_SIN_C: inner_reg <= grmc_pkg::SIN_C1 - {3'b0, m1[20:10]};
            grmc_pkg::DP_SIN_D: p_reg     <= grmc_pkg::SIN_C0 - {1'b0, m2[23:10]};
            grmc_pkg::DP_SIN_E:
                sin_reg[cmd.sin_sel] <= neg_reg ? -SW'(smag) : SW'(smag);
            default: ;
        endcase
    end

    // Steps and march
    logic signed [STW-1:0] sx_reg, sy_reg;
    logic signed [PW-1:0]  pos_x_reg, pos_y_reg, tst_x_reg, tst_y_reg;
    logic signed [PW-1:0]  ox, oy;
    logic                  tst_oob_reg;
    logic signed [CLW-1:0] icx, icy;
    logic                  oob;
    logic [2*SNW+1:0]      stx_prod, sty_prod;
    logic [15:0]           stx_q, sty_q;

    // Step size |sine| * 4 / STEPS_PER_CELL by reciprocal multiplication
    assign stx_prod = (2*SNW+2)'({mag_x, 2'b00}) * (2*SNW+2)'(STEP_M);
    assign sty_prod = (2*SNW+2)'({mag_y, 2'b00}) * (2*SNW+2)'(STEP_M);
    assign stx_q    = 16'(stx_prod >> STEP_S);
    assign sty_q    = 16'(sty_prod >> STEP_S);

    assign ox  = PW'({origin_x_reg, 8'b0});
    assign oy  = PW'({origin_y_reg, 8'b0});
    assign icx = pos_x_reg[PW-1:FW];
    assign icy = pos_y_reg[PW-1:FW];
    assign oob = icx[CLW-1] || icy[CLW-1]
              || (icx >= CLW'(GRID_SIZE)) || (icy >= CLW'(GRID_SIZE));
    assign ram_raddr = AW'(int'(icy[IW-1:0]) * GRID_SIZE + int'(icx[IW-1:0]));

    always_ff @(posedge aclk) begin
        case (cmd.op)
            grmc_pkg::DP_STEPX_TAKE:
                sx_reg <= sin_reg[0][SW-1] ? -STW'(stx_q) : STW'(stx_q);
            grmc_pkg::DP_STEPY_TAKE: begin
                sy_reg    <= sin_reg[1][SW-1] ? -STW'(sty_q) : STW'(sty_q);
                pos_x_reg <= ox;
                pos_y_reg <= oy;
            end
            grmc_pkg::DP_MARCH: begin
                tst_x_reg   <= pos_x_reg;
                tst_y_reg   <= pos_y_reg;
                tst_oob_reg <= oob;
                pos_x_reg   <= pos_x_reg + PW'(sx_reg);
                pos_y_reg   <= pos_y_reg + PW'(sy_reg);
            end
            default: ;
        endcase
    end

    // Distance
    logic signed [grmc_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [DSW-1:0]              d_reg;
    logic                               hit_reg;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            grmc_pkg::DP_DIST_MUL: begin
                prod_x_reg <= (tst_x_reg - ox) * sin_reg[2];
                prod_y_reg <= (tst_y_reg - oy) * sin_reg[3];
                hit_reg    <= 1'b1;
            end
            grmc_pkg::DP_NOHIT:    hit_reg <= 1'b0;
            grmc_pkg::DP_DIST_SUM: d_reg <= DSW'(prod_x_reg) + DSW'(prod_y_reg);
            default: ;
        endcase
    end

    // Divider operand select: only the line height needs a true division
    always_comb begin
        div_start = 1'b0;
        div_short = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            grmc_pkg::DP_H_START: begin
                div_start = st.d_pos;
                div_num   = {HALF, 30'b0};
                div_den   = d_reg[DW-1:0];
            end
            default: ;
        endcase
    end

    grmc_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .short_mode (div_short),
        .num        (div_num),
        .den        (div_den),
        .busy       (div_busy),
        .quot       (div_quot)
    );

    // Face, texture, line rows
    logic [1:0]            carried_face_reg, face_next;
    logic [8:0]            carried_u_reg, u_next;
    logic signed [PW-1:0]  prev_x, prev_y;
    logic signed [CLW-1:0] hcx, hcy, qcx, qcy;
    logic [8:0]            fx, fy;
    logic signed [DSW-1:0] half_s, h_s;
    logic signed [15:0]    top, bottom;
    logic                  m_valid_reg;
    grmc_pkg::out_item_t   m_data_reg;

    assign prev_x = tst_x_reg - PW'(sx_reg);
    assign prev_y = tst_y_reg - PW'(sy_reg);
    assign hcx = tst_x_reg[PW-1:FW];
    assign hcy = tst_y_reg[PW-1:FW];
    assign qcx = prev_x[PW-1:FW];
    assign qcy = prev_y[PW-1:FW];
    assign fx  = {1'b0, tst_x_reg[FW-1:8]};
    assign fy  = {1'b0, tst_y_reg[FW-1:8]};
    assign half_s = DSW'(HALF);
    assign h_s    = DSW'(div_quot);

    always_comb begin
        face_next = carried_face_reg;
        u_next    = carried_u_reg;
        if (hit_reg && !(hcx != qcx && hcy != qcy)) begin
            if (hcx < qcx) begin
                face_next = grmc_pkg::FACE_X_DEC;
                u_next    = 9'd256 - fy;
            end else if (hcy < qcy) begin
                face_next = grmc_pkg::FACE_Y_DEC;
                u_next    = fx;
            end else if (hcy > qcy) begin
                face_next = grmc_pkg::FACE_Y_INC;
                u_next    = 9'd256 - fx;
            end else begin
                face_next = grmc_pkg::FACE_X_INC;
                u_next    = fy;
            end
        end
        if (!hit_reg) begin
            top    = 16'(HALF);
            bottom = 16'(HALF);
        end else if (!st.d_pos) begin
            top    = -16'sd32768;
            bottom = 16'sd32767;
        end else begin
            top    = grmc_pkg::sat16(half_s - h_s);
            bottom = grmc_pkg::sat16(half_s + h_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carried_face_reg <= '0;
            carried_u_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.op == grmc_pkg::DP_CAST_LOAD && s_data.column == 9'd0) begin
                carried_face_reg <= '0;
                carried_u_reg    <= '0;
            end else if (cmd.op == grmc_pkg::DP_FINISH) begin
                carried_face_reg <= face_next;
                carried_u_reg    <= u_next;
            end
            if (cmd.op == grmc_pkg::DP_FINISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == grmc_pkg::DP_FINISH) begin
            m_data_reg.screen_column <= COL_LAST - column_reg;
            m_data_reg.hit           <= hit_reg;
            m_data_reg.wall_face     <= face_next;
            m_data_reg.texture_u     <= u_next;
            m_data_reg.line_top      <= top;
            m_data_reg.line_bottom   <= bottom;
        end
    end

    assign m_data = m_data_reg;
    assign m_valid = m_valid_reg;

    assign st.clear_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign st.div_busy   = div_busy;
    assign st.wall       = tst_oob_reg | ram_rdata;
    assign st.d_pos      = (d_reg > DSW'(0));
    assign st.out_free   = !m_valid_reg || m_ready;
endmodule

FILE: rtl/core/grmc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_ctrl: sequencer of the grid ray march column block
// Steps the datapath through clear, angle, sine, step, march, distance and
// result phases; counts march steps.
// ----------------------------------------------------------------------------
module grmc_ctrl #(
    parameter int MAX_STEPS = grmc_pkg::MAX_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_action,
    output logic                 s_ready,
    input  grmc_pkg::dp_stat_t   st,
    output grmc_pkg::dp_cmd_t    cmd
);
    localparam int NCW = $clog2(MAX_STEPS + 1);

    grmc_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]     sel_reg, sel_next;
    logic [NCW-1:0] n_reg, n_next;
    logic           tv_reg, tv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grmc_pkg::ST_CLEAR;
            sel_reg   <= '0;
            n_reg     <= '0;
            tv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            n_reg     <= n_next;
            tv_reg    <= tv_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        n_next      = n_reg;
        tv_next     = tv_reg;
        s_ready     = 1'b0;
        cmd.op      = grmc_pkg::DP_NOP;
        cmd.sin_sel = sel_reg;
        case (state_reg)
            grmc_pkg::ST_CLEAR: begin
                cmd.op = grmc_pkg::DP_CLEAR;
                if (st.clear_last) begin
                    state_next = grmc_pkg::ST_IDLE;
                end
            end
            grmc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == grmc_pkg::ACT_CAST) begin
                        cmd.op     = grmc_pkg::DP_CAST_LOAD;
                        state_next = grmc_pkg::ST_ANG;
                    end else begin
                        cmd.op = grmc_pkg::DP_CELL_WR;
                    end
                end
            end
            grmc_pkg::ST_ANG: begin
                if (!st.div_busy) begin
                    cmd.op     = grmc_pkg::DP_ANG_TAKE;
                    sel_next   = '0;
                    state_next = grmc_pkg::ST_SIN_A;
                end
            end
            grmc_pkg::ST_SIN_A: begin
                cmd.op     = grmc_pkg::DP_SIN_A;
                state_next = grmc_pkg::ST_SIN_B;
            end
            grmc_pkg::ST_SIN_B: begin
                cmd.op     = grmc_pkg::DP_SIN_B;
                state_next = grmc_pkg::ST_SIN_C;
            end
            grmc_pkg::ST_SIN_C: begin
                cmd.op     = grmc_pkg::DP_SIN_C;
                state_next = grmc_pkg::ST_SIN_D;
            end
            grmc_pkg::ST_SIN_D: begin
                cmd.op     = grmc_pkg::DP_SIN_D;
                state_next = grmc_pkg::ST_SIN_E;
            end
            grmc_pkg::ST_SIN_E: begin
                cmd.op = grmc_pkg::DP_SIN_E;
                if (sel_reg == 2'd3) begin
                    state_next = grmc_pkg::ST_STEPX;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = grmc_pkg::ST_SIN_A;
                end
            end
            grmc_pkg::ST_STEPX: begin
                cmd.op     = grmc_pkg::DP_STEPX_START;
                state_next = grmc_pkg::ST_STEPX_W;
            end
            grmc_pkg::ST_STEPX_W: begin
                if (!st.div_busy) begin
                    cmd.op     = grmc_pkg::DP_STEPX_TAKE;
                    state_next = grmc_pkg::ST_STEPY_W;
                end
            end
            grmc_pkg::ST_STEPY_W: begin
                if (!st.div_busy) begin
                    cmd.op     = grmc_pkg::DP_STEPY_TAKE;
                    n_next     = '0;
                    tv_next    = 1'b0;
                    state_next = grmc_pkg::ST_MARCH;
                end
            end
            grmc_pkg::ST_MARCH: begin
                if (tv_reg && st.wall) begin
                    cmd.op     = grmc_pkg::DP_DIST_MUL;
                    state_next = grmc_pkg::ST_DSUM;
                end else if (tv_reg && n_reg == NCW'(MAX_STEPS)) begin
                    cmd.op     = grmc_pkg::DP_NOHIT;
                    state_next = grmc_pkg::ST_FINISH;
                end else begin
                    cmd.op  = grmc_pkg::DP_MARCH;
                    tv_next = 1'b1;
                    if (tv_reg) begin
                        n_next = n_reg + NCW'(1);
                    end
                end
            end
            grmc_pkg::ST_DSUM: begin
                cmd.op     = grmc_pkg::DP_DIST_SUM;
                state_next = grmc_pkg::ST_DCHK;
            end
            grmc_pkg::ST_DCHK: begin
                cmd.op     = grmc_pkg::DP_H_START;
                state_next = st.d_pos ? grmc_pkg::ST_HWAIT : grmc_pkg::ST_FINISH;
            end
            grmc_pkg::ST_HWAIT: begin
                if (!st.div_busy) begin
                    state_next = grmc_pkg::ST_FINISH;
                end
            end
            grmc_pkg::ST_FINISH: begin
                if (st.out_free) begin
                    cmd.op     = grmc_pkg::DP_FINISH;
                    state_next = grmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = grmc_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/core/grid_ray_march_column_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_march_column_top: fixed-step grid ray caster, one screen column
// Keeps a GRID_SIZE x GRID_SIZE wall map and casts the ray of one column.
// ----------------------------------------------------------------------------
// After reset the block sweeps the wall map to open, one cell per cycle;
// s_ready stays low until the sweep ends, while config writes are taken at
// any time. A write transaction (action 0) yields no result. A cast
// transaction that hits a wall runs four sine evaluations, each through
// steps A to E, the serial divider for the line height with its hand-off,
// eight steps (accept, angle, two step sizes, their hand-off, distance sum,
// distance check, finish) and the march steps. A cast with no hit skips the
// distance and division; a hit at a distance that is not positive skips
// only the division. The march reads one map cell per cycle from the single
// read port of the map RAM; the column angle and the step sizes divide by
// constants through reciprocal multiplication. One transaction is worked
// on at a time; a finished result sits in the output register, so the next
// transaction is accepted while it waits for m_ready, and a further result
// holds in the finish step until that register is free.
module grid_ray_march_column_top #(
    parameter int GRID_SIZE      = grmc_pkg::GRID_SIZE_DEF,
    parameter int COLUMNS        = grmc_pkg::COLUMNS_DEF,
    parameter int ROWS           = grmc_pkg::ROWS_DEF,
    parameter int STEPS_PER_CELL = grmc_pkg::STEPS_PER_CELL_DEF,
    parameter int MAX_STEPS      = grmc_pkg::MAX_STEPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [grmc_pkg::CFG_W-1:0]  cfg_data,
    // input transactions
    input  logic                        s_valid,
    output logic                        s_ready,
    input  grmc_pkg::in_item_t          s_data,
    // result transactions
    output logic                        m_valid,
    input  logic                        m_ready,
    output grmc_pkg::out_item_t         m_data
);
    grmc_pkg::dp_cmd_t  cmd;
    grmc_pkg::dp_stat_t st;

    // Sequencer: decides the datapath operation of every cycle
    grmc_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_data.action),
        .s_ready  (s_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: map, sine, divider, march, distance, result register
    grmc_dp #(
        .GRID_SIZE      (GRID_SIZE),
        .COLUMNS        (COLUMNS),
        .ROWS           (ROWS),
        .STEPS_PER_CELL (STEPS_PER_CELL)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .st        (st)
    );

    // A result appears only from the finish step
    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.op == grmc_pkg::DP_FINISH))
        else $error("result raised without finish step");

    // Never accept a transaction while the divider is still running
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !st.div_busy)
        else $error("input ready while divider busy");

    // Finish only writes the output register when it is free
    a_finish_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == grmc_pkg::DP_FINISH) |-> (!m_valid || m_ready))
        else $error("result register overwritten");
endmodule
